// ===== src/ptb_pkg.sv =====
// shared constants, codes and control structs for the page table builder
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

    localparam int POOL_TABLES   = 16;
    localparam int TABLE_ENTRIES = 512;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int TBL_W         = $clog2(POOL_TABLES + 1);
    localparam int ADDR_W        = TBL_W + IDX_W;
    localparam int STORE_WORDS   = (POOL_TABLES + 1) * TABLE_ENTRIES;
    localparam int TNUM_W        = 5;
    localparam int CMP_W         = (TBL_W > TNUM_W) ? TBL_W : TNUM_W;
    localparam int PPN_W         = 44;
    localparam int VPN_W         = 45;
    localparam int LVL_W         = 3;
    localparam int WORD_W        = 64;
    localparam int USED_W        = 5;

    localparam logic [1:0] OP_MAP   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_MAPPED  = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_DONE    = 2'd3;

    localparam logic [1:0] WSEL_ZERO = 2'd0;
    localparam logic [1:0] WSEL_MEMQ = 2'd1;
    localparam logic [1:0] WSEL_LEAF = 2'd2;

    typedef struct packed {
        logic       load_req;
        logic       walk_start;
        logic       walk_read;
        logic       req_read;
        logic       follow;
        logic       alloc;
        logic       sweep_root;
        logic       sweep_step;
        logic       level_dec;
        logic       leaf_write;
        logic       pool_reset;
        logic       res_set;
        logic [1:0] res_status;
        logic [1:0] res_wsel;
    } cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       entry_valid;
        logic       stray;
        logic       pool_full;
        logic       at_leaf;
        logic       sweep_last;
        logic       read_ok;
    } stat_t;

endpackage
`default_nettype wire

// ===== src/ptb_ctrl.sv =====
// controller state machine for the page table builder
`timescale 1ns / 1ps
`default_nettype none
module ptb_ctrl (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire            out_free,
    output logic           out_load,
    input  ptb_pkg::stat_t st,
    output ptb_pkg::cmd_t  cmd
);
    import ptb_pkg::*;

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DECODE   = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CHK = 3'd4;
    localparam logic [2:0] S_FILL     = 3'd5;
    localparam logic [2:0] S_REQ_RD   = 3'd6;
    localparam logic [2:0] S_SWEEP    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = done_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        if (done_reg)
        begin
            // result waits for the output register
            if (out_free)
            begin
                out_load  = 1'b1;
                done_next = 1'b0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    cmd.sweep_step = 1'b1;
                    if (st.sweep_last)
                        state_next = S_IDLE;
                end
                S_IDLE:
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    unique case (st.opcode)
                        OP_MAP:
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK_RD;
                        end
                        OP_READ:
                        begin
                            if (st.read_ok)
                            begin
                                cmd.req_read = 1'b1;
                                state_next   = S_REQ_RD;
                            end
                            else
                            begin
                                cmd.res_set    = 1'b1;
                                cmd.res_status = ST_DONE;
                                cmd.res_wsel   = WSEL_ZERO;
                                done_next      = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.sweep_root = 1'b1;
                            cmd.pool_reset = 1'b1;
                            state_next     = S_SWEEP;
                        end
                        default:
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_DONE;
                            cmd.res_wsel   = WSEL_ZERO;
                            done_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                    endcase
                end
                S_WALK_RD:
                begin
                    cmd.walk_read = 1'b1;
                    state_next    = S_WALK_CHK;
                end
                S_WALK_CHK:
                begin
                    if (st.at_leaf)
                    begin
                        cmd.res_set = 1'b1;
                        if (st.entry_valid)
                        begin
                            cmd.res_status = ST_PRESENT;
                            cmd.res_wsel   = WSEL_MEMQ;
                        end
                        else
                        begin
                            cmd.leaf_write = 1'b1;
                            cmd.res_status = ST_MAPPED;
                            cmd.res_wsel   = WSEL_LEAF;
                        end
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (st.entry_valid)
                    begin
                        if (st.stray)
                        begin
                            cmd.res_set    = 1'b1;
                            cmd.res_status = ST_ERROR;
                            cmd.res_wsel   = WSEL_ZERO;
                            done_next      = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.follow = 1'b1;
                            state_next = S_WALK_RD;
                        end
                    end
                    else if (st.pool_full)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_ERROR;
                        cmd.res_wsel   = WSEL_ZERO;
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.alloc  = 1'b1;
                        state_next = S_FILL;
                    end
                end
                S_FILL:
                begin
                    cmd.sweep_step = 1'b1;
                    if (st.sweep_last)
                    begin
                        cmd.level_dec = 1'b1;
                        state_next    = S_WALK_RD;
                    end
                end
                S_REQ_RD:
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_DONE;
                    cmd.res_wsel   = WSEL_MEMQ;
                    done_next      = 1'b1;
                    state_next     = S_IDLE;
                end
                S_SWEEP:
                begin
                    cmd.sweep_step = 1'b1;
                    if (st.sweep_last)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_DONE;
                        cmd.res_wsel   = WSEL_ZERO;
                        done_next      = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/ptb_datapath.sv =====
// table store, walk registers and pool allocator for the page table builder
`timescale 1ns / 1ps
`default_nettype none
module ptb_datapath (
    input  wire                         clk,
    input  wire                         rst_n,
    input  ptb_pkg::cmd_t               cmd,
    output ptb_pkg::stat_t              st,
    input  wire [1:0]                   opcode,
    input  wire [ptb_pkg::VPN_W-1:0]    virt_page,
    input  wire [ptb_pkg::PPN_W-1:0]    phys_page,
    input  wire                         writable,
    input  wire [ptb_pkg::TNUM_W-1:0]   table_number,
    input  wire [ptb_pkg::IDX_W-1:0]    entry_index,
    input  wire [2:0]                   walk_depth,
    input  wire [ptb_pkg::PPN_W-1:0]    pool_base_page,
    output logic [1:0]                  res_status,
    output logic [ptb_pkg::WORD_W-1:0]  res_word,
    output logic [ptb_pkg::USED_W-1:0]  tables_used
);
    import ptb_pkg::*;

    logic [1:0]        op_reg;
    logic [VPN_W-1:0]  vpn_reg;
    logic [PPN_W-1:0]  ppn_reg;
    logic              wr_reg;
    logic [TNUM_W-1:0] tnum_reg;
    logic [IDX_W-1:0]  eidx_reg;

    logic [LVL_W-1:0]  level_reg;
    logic [TBL_W-1:0]  table_reg;
    logic [TBL_W-1:0]  pool_next_reg;
    logic [TBL_W-1:0]  sw_tbl_reg;
    logic [IDX_W-1:0]  sw_cnt_reg;
    logic [1:0]        res_status_reg;
    logic [WORD_W-1:0] res_word_reg;

    logic [WORD_W-1:0] mem [0:STORE_WORDS-1];
    logic [WORD_W-1:0] mem_q;

    logic [LVL_W-1:0]  top_level;
    logic [IDX_W-1:0]  walk_idx;
    logic [PPN_W-1:0]  offset;
    logic [CMP_W-1:0]  pool_ext;
    logic [CMP_W-1:0]  tnum_ext;
    logic [WORD_W-1:0] leaf_word;
    logic [WORD_W-1:0] ptr_word;
    logic [TBL_W-1:0]  new_table;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;

    // depth outside 3..5 is clamped
    always_comb
    begin
        if (walk_depth < 3'd3)
            top_level = 3'd2;
        else if (walk_depth > 3'd5)
            top_level = 3'd4;
        else
            top_level = walk_depth - 3'd1;
    end

    always_comb
    begin
        unique case (level_reg)
            3'd0:    walk_idx = vpn_reg[8:0];
            3'd1:    walk_idx = vpn_reg[17:9];
            3'd2:    walk_idx = vpn_reg[26:18];
            3'd3:    walk_idx = vpn_reg[35:27];
            3'd4:    walk_idx = vpn_reg[44:36];
            default: walk_idx = vpn_reg[8:0];
        endcase
    end

    assign offset    = mem_q[PPN_W+9:10] - pool_base_page;
    assign pool_ext  = CMP_W'(pool_next_reg);
    assign tnum_ext  = CMP_W'(tnum_reg);
    assign new_table = pool_next_reg + TBL_W'(1);
    assign leaf_word = {10'd0, ppn_reg, 2'b00, 5'b11001, wr_reg, 2'b11};
    assign ptr_word  = {10'd0, pool_base_page + PPN_W'(pool_next_reg), 10'd1};

    assign st.opcode      = op_reg;
    assign st.entry_valid = mem_q[0];
    assign st.stray       = offset >= PPN_W'(pool_next_reg);
    assign st.pool_full   = pool_next_reg == TBL_W'(POOL_TABLES);
    assign st.at_leaf     = level_reg == '0;
    assign st.sweep_last  = sw_cnt_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign st.read_ok     = (tnum_ext <= pool_ext) && (tnum_ext <= CMP_W'(POOL_TABLES));

    always_comb
    begin
        we    = 1'b0;
        waddr = {sw_tbl_reg, sw_cnt_reg};
        wdata = '0;
        if (cmd.leaf_write)
        begin
            we    = 1'b1;
            waddr = {table_reg, walk_idx};
            wdata = leaf_word;
        end
        else if (cmd.alloc)
        begin
            we    = 1'b1;
            waddr = {table_reg, walk_idx};
            wdata = ptr_word;
        end
        else if (cmd.sweep_step)
        begin
            we = 1'b1;
        end
        re    = cmd.walk_read | cmd.req_read;
        raddr = cmd.req_read ? {tnum_ext[TBL_W-1:0], eidx_reg} : {table_reg, walk_idx};
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            mem_q <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg   <= opcode;
            vpn_reg  <= virt_page;
            ppn_reg  <= phys_page;
            wr_reg   <= writable;
            tnum_reg <= table_number;
            eidx_reg <= entry_index;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            unique case (cmd.res_wsel)
                WSEL_MEMQ: res_word_reg <= mem_q;
                WSEL_LEAF: res_word_reg <= leaf_word;
                default:   res_word_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            table_reg     <= '0;
            pool_next_reg <= '0;
            sw_tbl_reg    <= '0;
            sw_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                level_reg <= top_level;
                table_reg <= '0;
            end
            if (cmd.follow)
            begin
                table_reg <= offset[TBL_W-1:0] + TBL_W'(1);
                level_reg <= level_reg - LVL_W'(1);
            end
            if (cmd.level_dec)
                level_reg <= level_reg - LVL_W'(1);
            if (cmd.alloc)
            begin
                table_reg     <= new_table;
                sw_tbl_reg    <= new_table;
                sw_cnt_reg    <= '0;
                pool_next_reg <= new_table;
            end
            if (cmd.sweep_root)
            begin
                sw_tbl_reg <= '0;
                sw_cnt_reg <= '0;
            end
            if (cmd.pool_reset)
                pool_next_reg <= '0;
            if (cmd.sweep_step)
                sw_cnt_reg <= sw_cnt_reg + IDX_W'(1);
        end
    end

    assign res_status  = res_status_reg;
    assign res_word    = res_word_reg;
    assign tables_used = pool_ext[USED_W-1:0];

endmodule
`default_nettype wire

// ===== src/page_table_builder_core.sv =====
// top level of the page table builder: register port, output register, instances
// Builds RISC-V page tables in a local 64-bit store (root plus 16 pool tables of 512
// entries), one request at a time. After reset a clearing pass zeroes the root before
// the first request is taken. A map request does one store read and one check per
// level, and every new table must be swept clear, one entry at a time, through the
// store's write port. The result sits in an output register, so the next request is
// taken while it waits.
`timescale 1ns / 1ps
`default_nettype none
module page_table_builder_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [3:0]   paddr,
    input  wire [63:0]  pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [1:0]   opcode,
    input  wire [44:0]  virt_page,
    input  wire [43:0]  phys_page,
    input  wire         writable,
    input  wire [4:0]   table_number,
    input  wire [8:0]   entry_index,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  status,
    output logic [63:0] entry_word,
    output logic [4:0]  tables_used
);
    import ptb_pkg::*;

    localparam logic REG_DEPTH     = 1'b0;
    localparam logic REG_POOL_BASE = 1'b1;

    logic [2:0]        depth_reg;
    logic [PPN_W-1:0]  pool_base_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] word_reg;
    logic [USED_W-1:0] used_reg;

    cmd_t              cmd;
    stat_t             st;
    logic              out_free;
    logic              out_load;
    logic [1:0]        res_status;
    logic [WORD_W-1:0] res_word;
    logic [USED_W-1:0] res_used;

    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[3])
            REG_DEPTH: prdata = {61'd0, depth_reg};
            default:   prdata = {20'd0, pool_base_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= 3'd3;
            pool_base_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3] == REG_POOL_BASE)
                pool_base_reg <= pwdata[PPN_W-1:0];
            else
                depth_reg <= pwdata[2:0];
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg <= res_status;
            word_reg   <= res_word;
            used_reg   <= res_used;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_word  = word_reg;
    assign tables_used = used_reg;

    ptb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_free (out_free),
        .out_load (out_load),
        .st       (st),
        .cmd      (cmd)
    );

    ptb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .opcode         (opcode),
        .virt_page      (virt_page),
        .phys_page      (phys_page),
        .writable       (writable),
        .table_number   (table_number),
        .entry_index    (entry_index),
        .walk_depth     (depth_reg),
        .pool_base_page (pool_base_reg),
        .res_status     (res_status),
        .res_word       (res_word),
        .tables_used    (res_used)
    );

endmodule
`default_nettype wire
